// ----- design/msa_rle_pkg.sv -----
// ----------------------------------------------------------------------------
// msa_rle_pkg
// Shared types and constants for the MSA track RLE decoder: stream payloads,
// header layout, token codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package msa_rle_pkg;

    // field widths fixed by the stream format
    localparam int OFFSET_W     = 24;
    localparam int SECTOR_SHIFT = 9;    // 512 bytes per sector

    // signature and run token bytes
    localparam logic [7:0] SIG_BYTE0 = 8'h0E;
    localparam logic [7:0] SIG_BYTE1 = 8'h0F;
    localparam logic [7:0] RUN_MARK  = 8'hE5;

    // header byte positions
    localparam logic [3:0] HDR_SIG0     = 4'd0;
    localparam logic [3:0] HDR_SIG1     = 4'd1;
    localparam logic [3:0] HDR_SECTORS  = 4'd3;
    localparam logic [3:0] HDR_SIDES    = 4'd5;
    localparam logic [3:0] HDR_TRACK_HI = 4'd8;
    localparam logic [3:0] HDR_TRACK_LO = 4'd9;

    // result error codes
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_SIG  = 2'd1;
    localparam logic [1:0] ERR_CAP  = 2'd2;

    // input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } t_in;

    // result item
    typedef struct packed {
        logic [7:0]          value;
        logic [15:0]         repeat_res;
        logic [OFFSET_W-1:0] offset;
        logic [1:0]          error_code;
        logic                last;
    } t_out;

    // kind of result the datapath builds
    typedef enum logic [2:0] {
        RES_MARKER,
        RES_LITERAL,
        RES_RUN,
        RES_ERR_SIG,
        RES_ERR_CAP
    } t_res_sel;

    // controller to datapath commands
    typedef struct packed {
        logic     hdr_step;
        logic     mul1;
        logic     mul2;
        logic     cap_load;
        logic     size_hi_load;
        logic     size_lo_load;
        logic     rec_dec;
        logic     records_dec;
        logic     run_val_load;
        logic     run_hi_load;
        logic     off_add_one;
        logic     off_add_run;
        logic     emit;
        t_res_sel res_sel;
        logic     res_last;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic sig_bad;
        logic hdr_last;
        logic size_zero;
        logic size_raw;
        logic byte_mark;
        logic off_full;
        logic run_zero;
        logic run_over;
        logic rec_last;
        logic records_last;
        logic records_zero;
        logic res_busy;
    } t_dp_status;

endpackage

// ----- design/msa_rle_dp.sv -----
// ----------------------------------------------------------------------------
// msa_rle_dp
// Datapath of the MSA track decoder: header fields, capacity multiply,
// record and run counters, image offset, result register and output stage.
// ----------------------------------------------------------------------------
module msa_rle_dp #(
    parameter int IMAGE_ADDR_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  msa_rle_pkg::t_dp_cmd   i_cmd,
    input  msa_rle_pkg::t_in       i_in,
    output msa_rle_pkg::t_dp_status o_status,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output msa_rle_pkg::t_out      o_out
);

    localparam int OFF_W  = IMAGE_ADDR_BITS + 1;
    localparam int PROD_W = 33;
    localparam int CAP_W  = PROD_W + msa_rle_pkg::SECTOR_SHIFT;
    localparam int OUT_W  = msa_rle_pkg::OFFSET_W;
    localparam int EXT_W  = OFF_W + OUT_W;

    logic [3:0]        r_hdr_idx;
    logic [7:0]        r_sectors;
    logic [7:0]        r_sides;
    logic [15:0]       r_track;
    logic [15:0]       r_prod1;
    logic [23:0]       r_records;
    logic [PROD_W-1:0] r_prod2;
    logic [OFF_W-1:0]  r_capacity;
    logic [OFF_W-1:0]  r_offset;
    logic [15:0]       r_rec_bytes;
    logic [7:0]        r_run_val;
    logic [7:0]        r_run_hi;
    logic              r_res_valid;
    msa_rle_pkg::t_out r_res;
    logic              r_out_valid;
    msa_rle_pkg::t_out r_out;

    logic [3:0]        w_idx;
    logic [7:0]        w_byte;
    logic [15:0]       w_size;
    logic [16:0]       w_raw_size;
    logic [15:0]       w_run_len;
    logic [OFF_W:0]    w_run_end;
    logic [15:0]       w_track_next;
    logic [16:0]       w_track_plus;
    logic [15:0]       w_prod1;
    logic [23:0]       w_records;
    logic [PROD_W-1:0] w_prod2;
    logic [CAP_W-1:0]  w_cap_full;
    logic [CAP_W-1:0]  w_cap_limit;
    logic [CAP_W-1:0]  w_cap_sel;
    logic [EXT_W-1:0]  w_off_ext;
    logic              w_move;
    msa_rle_pkg::t_out w_res;

    // header index restarts on a new file
    assign w_idx  = i_in.start_of_file ? 4'd0 : r_hdr_idx;
    assign w_byte = i_in.data_byte;

    // record size, raw track size and run length
    assign w_size       = {r_rec_bytes[7:0], w_byte};
    assign w_raw_size   = {r_sectors, {msa_rle_pkg::SECTOR_SHIFT{1'b0}}};
    assign w_run_len    = {r_run_hi, w_byte};
    assign w_run_end    = {1'b0, r_offset} + (OFF_W + 1)'(w_run_len);
    assign w_track_next = {r_track[7:0], w_byte} + 16'd1;
    assign w_track_plus = {1'b0, r_track} + 17'd1;

    // capacity products and record count, registered under mul1 and then mul2
    assign w_prod1     = 16'(r_sectors) * 16'(r_sides);
    assign w_records   = 24'(r_track) * 24'(r_sides);
    assign w_prod2     = PROD_W'(r_prod1) * PROD_W'(w_track_plus);
    assign w_cap_full  = {r_prod2, {msa_rle_pkg::SECTOR_SHIFT{1'b0}}};
    assign w_cap_limit = CAP_W'(1) << IMAGE_ADDR_BITS;
    assign w_cap_sel   = (w_cap_full > w_cap_limit) ? w_cap_limit : w_cap_full;

    // image offset shown in the result
    assign w_off_ext = EXT_W'(r_offset);

    // status back to the controller
    always_comb begin
        o_status.sig_bad      = ((w_idx == msa_rle_pkg::HDR_SIG0)
                                 && (w_byte != msa_rle_pkg::SIG_BYTE0))
                             || ((w_idx == msa_rle_pkg::HDR_SIG1)
                                 && (w_byte != msa_rle_pkg::SIG_BYTE1));
        o_status.hdr_last     = (w_idx == msa_rle_pkg::HDR_TRACK_LO);
        o_status.size_zero    = (w_size == 16'd0);
        o_status.size_raw     = ({1'b0, w_size} == w_raw_size);
        o_status.byte_mark    = (w_byte == msa_rle_pkg::RUN_MARK);
        o_status.off_full     = (r_offset >= r_capacity);
        o_status.run_zero     = (w_run_len == 16'd0);
        o_status.run_over     = (w_run_end > {1'b0, r_capacity});
        o_status.rec_last     = (r_rec_bytes == 16'd1);
        o_status.records_last = (r_records == 24'd1);
        o_status.records_zero = (r_records == 24'd0);
        o_status.res_busy     = r_res_valid;
    end

    // result selection
    always_comb begin
        w_res.value      = 8'd0;
        w_res.repeat_res = 16'd0;
        w_res.offset     = w_off_ext[OUT_W-1:0];
        w_res.error_code = msa_rle_pkg::ERR_NONE;
        w_res.last       = i_cmd.res_last;
        case (i_cmd.res_sel)
            msa_rle_pkg::RES_LITERAL: begin
                w_res.value      = w_byte;
                w_res.repeat_res = 16'd1;
            end
            msa_rle_pkg::RES_RUN: begin
                w_res.value      = r_run_val;
                w_res.repeat_res = w_run_len;
            end
            msa_rle_pkg::RES_ERR_SIG: begin
                w_res.offset     = '0;
                w_res.error_code = msa_rle_pkg::ERR_SIG;
            end
            msa_rle_pkg::RES_ERR_CAP: begin
                w_res.error_code = msa_rle_pkg::ERR_CAP;
            end
            default: begin
            end
        endcase
    end

    // header index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx <= 4'd0;
        end else if (i_cmd.hdr_step) begin
            r_hdr_idx <= o_status.hdr_last ? 4'd0 : w_idx + 4'd1;
        end
    end

    // header fields and capacity
    always_ff @(posedge i_clk) begin
        if (i_cmd.hdr_step) begin
            case (w_idx)
                msa_rle_pkg::HDR_SECTORS:  r_sectors <= w_byte;
                msa_rle_pkg::HDR_SIDES:    r_sides   <= w_byte + 8'd1;
                msa_rle_pkg::HDR_TRACK_HI: r_track   <= {8'd0, w_byte};
                msa_rle_pkg::HDR_TRACK_LO: r_track   <= w_track_next;
                default: begin
                end
            endcase
        end
        if (i_cmd.mul1) begin
            r_prod1 <= w_prod1;
        end
        if (i_cmd.mul2) begin
            r_prod2 <= w_prod2;
        end
        if (i_cmd.cap_load) begin
            r_capacity <= w_cap_sel[OFF_W-1:0];
        end
    end

    // record counters, run token fields and image offset
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_records <= w_records;
        end else if (i_cmd.records_dec) begin
            r_records <= r_records - 24'd1;
        end
        if (i_cmd.size_hi_load) begin
            r_rec_bytes <= {8'd0, w_byte};
        end else if (i_cmd.size_lo_load) begin
            r_rec_bytes <= w_size;
        end else if (i_cmd.rec_dec) begin
            r_rec_bytes <= r_rec_bytes - 16'd1;
        end
        if (i_cmd.run_val_load) begin
            r_run_val <= w_byte;
        end
        if (i_cmd.run_hi_load) begin
            r_run_hi <= w_byte;
        end
        if (i_cmd.mul1) begin
            r_offset <= '0;
        end else if (i_cmd.off_add_one) begin
            r_offset <= r_offset + OFF_W'(1);
        end else if (i_cmd.off_add_run) begin
            r_offset <= w_run_end[OFF_W-1:0];
        end
    end

    // result register feeding the output stage
    assign w_move = r_res_valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_res_valid <= 1'b1;
            end else if (w_move) begin
                r_res_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_res <= w_res;
        end
        if (w_move) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- design/msa_rle_ctrl.sv -----
// ----------------------------------------------------------------------------
// msa_rle_ctrl
// Parser state machine of the MSA track decoder: walks header, capacity
// multiply, record sizes and raw or packed track bytes, and drives the
// datapath through a command struct.
// ----------------------------------------------------------------------------
module msa_rle_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic                    i_sof,
    input  msa_rle_pkg::t_dp_status i_status,
    output msa_rle_pkg::t_dp_cmd    o_cmd,
    output logic                    o_in_ready
);

    typedef enum logic [3:0] {
        ST_HEADER,
        ST_MUL1,
        ST_MUL2,
        ST_CAP,
        ST_SIZE_HI,
        ST_SIZE_LO,
        ST_RAW,
        ST_PACKED,
        ST_RUN_VAL,
        ST_RUN_HI,
        ST_RUN_LO,
        ST_DONE,
        ST_ERROR
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state w_eff;
    logic   w_busy;
    logic   w_fail;
    logic   w_tail;

    // capacity multiply takes no byte
    assign w_busy     = r_state inside {ST_MUL1, ST_MUL2, ST_CAP};
    assign o_in_ready = !w_busy && !i_status.res_busy;
    assign w_eff      = i_sof ? ST_HEADER : r_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_sel = msa_rle_pkg::RES_MARKER;
        w_fail  = 1'b0;
        w_tail  = 1'b0;
        if (w_busy) begin
            case (r_state)
                ST_MUL1: begin
                    o_cmd.mul1 = 1'b1;
                    n_state    = ST_MUL2;
                end
                ST_MUL2: begin
                    o_cmd.mul2 = 1'b1;
                    n_state    = ST_CAP;
                end
                default: begin
                    o_cmd.cap_load = 1'b1;
                    if (i_status.records_zero) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.res_last = 1'b1;
                        n_state        = ST_DONE;
                    end else begin
                        n_state = ST_SIZE_HI;
                    end
                end
            endcase
        end else if (i_accept) begin
            case (w_eff)
                ST_HEADER: begin
                    if (i_status.sig_bad) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.res_sel  = msa_rle_pkg::RES_ERR_SIG;
                        o_cmd.res_last = 1'b1;
                        n_state        = ST_ERROR;
                    end else begin
                        o_cmd.hdr_step = 1'b1;
                        n_state = i_status.hdr_last ? ST_MUL1 : ST_HEADER;
                    end
                end
                ST_SIZE_HI: begin
                    o_cmd.size_hi_load = 1'b1;
                    n_state            = ST_SIZE_LO;
                end
                ST_SIZE_LO: begin
                    o_cmd.size_lo_load = 1'b1;
                    if (i_status.size_zero) begin
                        // empty record
                        o_cmd.records_dec = 1'b1;
                        if (i_status.records_last) begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.res_last = 1'b1;
                            n_state        = ST_DONE;
                        end else begin
                            n_state = ST_SIZE_HI;
                        end
                    end else begin
                        n_state = i_status.size_raw ? ST_RAW : ST_PACKED;
                    end
                end
                ST_RAW, ST_PACKED: begin
                    w_tail = 1'b1;
                    if (w_eff == ST_PACKED && i_status.byte_mark) begin
                        n_state = ST_RUN_VAL;
                    end else if (i_status.off_full) begin
                        w_fail = 1'b1;
                    end else begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.res_sel     = msa_rle_pkg::RES_LITERAL;
                        o_cmd.off_add_one = 1'b1;
                    end
                end
                ST_RUN_VAL: begin
                    w_tail             = 1'b1;
                    o_cmd.run_val_load = 1'b1;
                    n_state            = ST_RUN_HI;
                end
                ST_RUN_HI: begin
                    w_tail            = 1'b1;
                    o_cmd.run_hi_load = 1'b1;
                    n_state           = ST_RUN_LO;
                end
                ST_RUN_LO: begin
                    w_tail  = 1'b1;
                    n_state = ST_PACKED;
                    if (!i_status.run_zero) begin
                        if (i_status.run_over) begin
                            w_fail = 1'b1;
                        end else begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.res_sel     = msa_rle_pkg::RES_RUN;
                            o_cmd.off_add_run = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase

            // overflow ends the file with an error result
            if (w_fail) begin
                o_cmd.emit     = 1'b1;
                o_cmd.res_sel  = msa_rle_pkg::RES_ERR_CAP;
                o_cmd.res_last = 1'b1;
                n_state        = ST_ERROR;
            end else if (w_tail) begin
                // count the record byte and close the record at its end
                o_cmd.rec_dec = 1'b1;
                if (i_status.rec_last) begin
                    o_cmd.records_dec = 1'b1;
                    if (i_status.records_last) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.res_last = 1'b1;
                        n_state        = ST_DONE;
                    end else begin
                        n_state = ST_SIZE_HI;
                    end
                end
            end
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HEADER;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/msa_track_rle_decoder.sv -----
// A result goes through the result register and then the output register.
// Throughput: one byte per cycle while no result is pending and no multiply runs;
//   a byte that gives a result holds the input until it moves to the output register.
// After the last header byte the input is held for the two-step capacity multiply.
// Reset (i_rst_n low, synchronous) returns the parser to the header and empties the
//   output; start_of_file on any byte restarts the parser without a reset.
// ----------------------------------------------------------------------------
// msa_track_rle_decoder
// MSA disk image decoder: checks the signature, reads the header, works out
// the image capacity and turns each track record into runs of image bytes.
// ----------------------------------------------------------------------------
module msa_track_rle_decoder #(
    parameter int IMAGE_ADDR_BITS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  msa_rle_pkg::t_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output msa_rle_pkg::t_out o_out_data
);

    msa_rle_pkg::t_dp_cmd    w_cmd;
    msa_rle_pkg::t_dp_status w_status;
    logic                    w_accept;

    // input transfer
    assign w_accept = i_in_valid && o_in_ready;

    // parser control
    msa_rle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_sof      (i_in_data.start_of_file),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_ready (o_in_ready)
    );

    // counters, capacity and result path
    msa_rle_dp #(
        .IMAGE_ADDR_BITS (IMAGE_ADDR_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in        (i_in_data),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

endmodule

// ----- design/msa_rle_checker.sv -----
// ----------------------------------------------------------------------------
// msa_rle_checker
// Port-level checks for the MSA track decoder, attached to the top level.
// ----------------------------------------------------------------------------
module msa_rle_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input msa_rle_pkg::t_out o_out_data
);

    // output is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // an error result ends the file
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.error_code != msa_rle_pkg::ERR_NONE)
        |-> o_out_data.last)
        else $error("error result without last");

    // an error result carries no bytes
    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.error_code != msa_rle_pkg::ERR_NONE)
        |-> (o_out_data.repeat_res == 16'd0) && (o_out_data.value == 8'd0))
        else $error("error result with data");

    // an empty result is only an end marker
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.repeat_res == 16'd0) |-> o_out_data.last)
        else $error("empty result not marked last");

endmodule

bind msa_track_rle_decoder msa_rle_checker u_msa_rle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
